// ===== rtl/itoa_fmt_pkg.sv =====
// Shared constants, microcode types and the control store of the integer formatter.
package itoa_fmt_pkg;

  localparam int VALUE_BITS = 32;
  localparam int MAX_FIELD  = 60;
  localparam int FIELD_W    = 6;
  localparam int CHAR_W     = 8;
  // Octal needs the most digits: one for every three value bits, rounded up.
  localparam int MAX_DIGITS = (VALUE_BITS + 2) / 3;
  localparam int ND_W       = $clog2(MAX_DIGITS + 1);
  localparam int DIG_IDX_W  = $clog2(MAX_DIGITS);
  localparam int PAD_W      = FIELD_W + 2;
  localparam int UPC_W      = 4;
  localparam int PROD_W     = 2 * VALUE_BITS;

  // floor(x / 10) == (x * DEC_RECIP) >> DEC_SHIFT for every 32-bit x.
  localparam logic [VALUE_BITS-1:0] DEC_RECIP = 32'hCCCC_CCCD;
  localparam int DEC_SHIFT = 35;

  localparam logic [1:0] BASE_OCT = 2'd0;
  localparam logic [1:0] BASE_DEC = 2'd1;

  localparam int FLG_ZERO   = 0;
  localparam int FLG_SIGNED = 1;
  localparam int FLG_PLUS   = 2;
  localparam int FLG_SPACE  = 3;
  localparam int FLG_LEFT   = 4;
  localparam int FLG_LOWER  = 5;
  localparam int FLG_PREFIX = 6;

  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_UPPERA = 8'h41;
  localparam logic [CHAR_W-1:0] CH_X      = 8'h58;
  localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CHAR_W-1:0] LOWER_BIT = 8'h20;

  typedef enum logic [2:0] {
    U_NOP, U_LOAD, U_DIV, U_DIG, U_PREC, U_PAD, U_EMIT_LOOP, U_EMIT_ONCE
  } uop_e;

  typedef enum logic [2:0] {
    SRC_SPACE, SRC_SIGN, SRC_ZERO, SRC_X, SRC_DIGIT
  } src_e;

  typedef enum logic [1:0] {
    CNT_PAD, CNT_PREC, CNT_ND
  } cnt_e;

  typedef enum logic [2:0] {
    C_ALWAYS, C_LEAD, C_SIGN, C_PREFIX, C_PREFIX_HEX, C_NOT_LEFT
  } cond_e;

  typedef struct packed {
    uop_e             op;
    src_e             src;
    cnt_e             cnt;
    cond_e            cond;
    logic             last_dig;
    logic             last_pad;
    logic [UPC_W-1:0] nxt;
    logic [UPC_W-1:0] alt;
  } uword_t;

  localparam logic [UPC_W-1:0] ST_LOAD   = 4'd0;
  localparam logic [UPC_W-1:0] ST_DIV    = 4'd1;
  localparam logic [UPC_W-1:0] ST_DIG    = 4'd2;
  localparam logic [UPC_W-1:0] ST_PREC   = 4'd3;
  localparam logic [UPC_W-1:0] ST_PAD    = 4'd4;
  localparam logic [UPC_W-1:0] ST_LEAD   = 4'd5;
  localparam logic [UPC_W-1:0] ST_SIGN   = 4'd6;
  localparam logic [UPC_W-1:0] ST_PFX0   = 4'd7;
  localparam logic [UPC_W-1:0] ST_PFX1   = 4'd8;
  localparam logic [UPC_W-1:0] ST_ZFILL  = 4'd9;
  localparam logic [UPC_W-1:0] ST_PZERO  = 4'd10;
  localparam logic [UPC_W-1:0] ST_DIGITS = 4'd11;
  localparam logic [UPC_W-1:0] ST_TRAIL  = 4'd12;

  // The control store: one word per step of the formatting program.
  function automatic uword_t ucode(input logic [UPC_W-1:0] addr);
    uword_t w;
    w = '{op: U_NOP, src: SRC_SPACE, cnt: CNT_PAD, cond: C_ALWAYS,
          last_dig: 1'b0, last_pad: 1'b0, nxt: ST_LOAD, alt: ST_LOAD};
    unique case (addr)
      ST_LOAD: begin
        w.op  = U_LOAD;
        w.nxt = ST_DIV;
      end
      ST_DIV: begin
        w.op  = U_DIV;
        w.nxt = ST_DIG;
      end
      ST_DIG: begin
        w.op  = U_DIG;
        w.nxt = ST_PREC;
        w.alt = ST_DIV;
      end
      ST_PREC: begin
        w.op  = U_PREC;
        w.nxt = ST_PAD;
      end
      ST_PAD: begin
        w.op  = U_PAD;
        w.nxt = ST_LEAD;
      end
      ST_LEAD: begin
        w.op   = U_EMIT_LOOP;
        w.src  = SRC_SPACE;
        w.cnt  = CNT_PAD;
        w.cond = C_LEAD;
        w.nxt  = ST_SIGN;
      end
      ST_SIGN: begin
        w.op   = U_EMIT_ONCE;
        w.src  = SRC_SIGN;
        w.cond = C_SIGN;
        w.nxt  = ST_PFX0;
      end
      ST_PFX0: begin
        w.op   = U_EMIT_ONCE;
        w.src  = SRC_ZERO;
        w.cond = C_PREFIX;
        w.nxt  = ST_PFX1;
      end
      ST_PFX1: begin
        w.op   = U_EMIT_ONCE;
        w.src  = SRC_X;
        w.cond = C_PREFIX_HEX;
        w.nxt  = ST_ZFILL;
      end
      ST_ZFILL: begin
        w.op   = U_EMIT_LOOP;
        w.src  = SRC_ZERO;
        w.cnt  = CNT_PAD;
        w.cond = C_NOT_LEFT;
        w.nxt  = ST_PZERO;
      end
      ST_PZERO: begin
        w.op   = U_EMIT_LOOP;
        w.src  = SRC_ZERO;
        w.cnt  = CNT_PREC;
        w.nxt  = ST_DIGITS;
      end
      ST_DIGITS: begin
        w.op       = U_EMIT_LOOP;
        w.src      = SRC_DIGIT;
        w.cnt      = CNT_ND;
        w.last_dig = 1'b1;
        w.nxt      = ST_TRAIL;
      end
      ST_TRAIL: begin
        w.op       = U_EMIT_LOOP;
        w.src      = SRC_SPACE;
        w.cnt      = CNT_PAD;
        w.last_pad = 1'b1;
        w.nxt      = ST_LOAD;
      end
      default: begin
        w.op  = U_NOP;
        w.nxt = ST_LOAD;
      end
    endcase
    return w;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic lower);
    logic [CHAR_W-1:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + CHAR_W'(d);
    end else begin
      c = CH_UPPERA + CHAR_W'(d) - CHAR_W'(10);
    end
    return lower ? (c | LOWER_BIT) : c;
  endfunction

endpackage

// ===== rtl/integer_to_ascii_formatter_core.sv =====
// Top level of the integer formatter: a microcoded sequencer that prints one number per request.
//
// Each accepted request carries a 32-bit value, a radix (octal, decimal, or hexadecimal, with
// code three taken as hexadecimal), a field width, a minimum digit count, and printf-style flags.
// The block returns the formatted text one ASCII character per output transfer, with last_char_o
// set on the final character. A request runs through a load step, a digit loop of a divide step
// and a digit step per extracted digit (at most 11 octal, 10 decimal, or 8 hex digits), two setup
// steps, and then the emit steps: five counted steps (leading spaces, zero fill, extra zeros,
// digits, trailing spaces) and the sign and prefix steps, which are passed over when they emit
// nothing. The single output register takes one character per cycle while the output side keeps
// ready high. The divide step runs a constant-reciprocal multiply for decimal and a shift
// otherwise; the digit step forms the remainder and writes the digit. The sequencer is back in
// its load step after the last character enters the output register, even if that character
// has not yet been taken, and only there does it accept a new request.
module integer_to_ascii_formatter_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [itoa_fmt_pkg::VALUE_BITS-1:0]   value_i,
  input  logic [1:0]                            base_select_i,
  input  logic [itoa_fmt_pkg::FIELD_W-1:0]      field_width_i,
  input  logic [itoa_fmt_pkg::FIELD_W-1:0]      min_digits_i,
  input  logic [6:0]                            format_flags_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [itoa_fmt_pkg::CHAR_W-1:0]       out_char_o,
  output logic                                  last_char_o
);
  import itoa_fmt_pkg::*;

  // Sequencer and its current control word.
  logic [UPC_W-1:0] upc_q, upc_d;
  uword_t           uw;

  // Datapath registers.
  logic [VALUE_BITS-1:0] mag_q, mag_d;
  logic [VALUE_BITS-1:0] quo_q, quo_d;
  logic                  hex_q, hex_d;
  logic                  dec_q, dec_d;
  logic                  zero_q, zero_d;
  logic                  left_q, left_d;
  logic                  lower_q, lower_d;
  logic                  prefix_q, prefix_d;
  logic                  sign_en_q, sign_en_d;
  logic [CHAR_W-1:0]     sign_char_q, sign_char_d;
  logic [FIELD_W-1:0]    prec_q, prec_d;
  logic [PAD_W-1:0]      pad_q, pad_d;
  logic [ND_W-1:0]       nd_q, nd_d;
  logic [3:0]            dig_q [MAX_DIGITS];

  // Output register.
  logic              out_valid_q, out_valid_d;
  logic [CHAR_W-1:0] out_char_q, out_char_d;
  logic              out_last_q, out_last_d;

  // Request decode, evaluated while the sequencer sits in its load step.
  logic                  in_fire;
  logic                  req_neg;
  logic                  req_sign_en;
  logic                  req_hex;
  logic                  req_oct;
  logic [FIELD_W-1:0]    req_width;
  logic [FIELD_W-1:0]    req_prec;
  logic [1:0]            req_pfx_len;

  // Digit extraction.
  logic [PROD_W-1:0]     prod;
  logic [3:0]            quo_x10_lo;
  logic [3:0]            rem;

  // Character emission.
  logic                  out_free;
  logic                  cond_ok;
  logic [FIELD_W-1:0]    cnt_val;
  logic                  emit;
  logic [CHAR_W-1:0]     src_char;
  logic [ND_W-1:0]       nd_dec;
  logic [PAD_W-1:0]      pad_sub;
  logic                  dig_we;

  assign uw         = ucode(upc_q);
  assign in_ready_o = (uw.op == U_LOAD);
  assign in_fire    = in_valid_i && in_ready_o;

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign last_char_o = out_last_q;

  // A negative signed value is printed by magnitude; the most negative value wraps onto itself,
  // which is exactly its magnitude read as unsigned.
  assign req_neg     = format_flags_i[FLG_SIGNED] & value_i[VALUE_BITS-1];
  assign req_sign_en = format_flags_i[FLG_SIGNED]
                     & (req_neg | format_flags_i[FLG_PLUS] | format_flags_i[FLG_SPACE]);
  assign req_hex     = base_select_i[1];
  assign req_oct     = (base_select_i == BASE_OCT);
  assign req_width   = (field_width_i > FIELD_W'(MAX_FIELD)) ? FIELD_W'(MAX_FIELD) : field_width_i;
  assign req_prec    = (min_digits_i > FIELD_W'(MAX_FIELD)) ? FIELD_W'(MAX_FIELD) : min_digits_i;
  assign req_pfx_len = !format_flags_i[FLG_PREFIX] ? 2'd0 :
                       req_hex                     ? 2'd2 :
                       req_oct                     ? 2'd1 : 2'd0;

  // Decimal division by ten uses a constant reciprocal; the remainder only needs the low nibble
  // of quotient times ten, which is (q << 3) + (q << 1) cut to four bits.
  assign prod       = PROD_W'(mag_q) * PROD_W'(DEC_RECIP);
  assign quo_x10_lo = {quo_q[0], 3'b000} + {quo_q[2:0], 1'b0};
  assign rem        = dec_q ? (mag_q[3:0] - quo_x10_lo) :
                      hex_q ? mag_q[3:0] : {1'b0, mag_q[2:0]};

  assign out_free = !out_valid_q || out_ready_i;
  assign nd_dec   = nd_q - 1'b1;
  assign pad_sub  = pad_q - PAD_W'(prec_q);

  always_comb begin
    unique case (uw.cond)
      C_ALWAYS:     cond_ok = 1'b1;
      C_LEAD:       cond_ok = !zero_q && !left_q;
      C_SIGN:       cond_ok = sign_en_q;
      C_PREFIX:     cond_ok = prefix_q && !dec_q;
      C_PREFIX_HEX: cond_ok = prefix_q && hex_q;
      C_NOT_LEFT:   cond_ok = !left_q;
      default:      cond_ok = 1'b0;
    endcase
  end

  always_comb begin
    unique case (uw.cnt)
      CNT_PAD:  cnt_val = pad_q[FIELD_W-1:0];
      CNT_PREC: cnt_val = prec_q;
      CNT_ND:   cnt_val = FIELD_W'(nd_q);
      default:  cnt_val = '0;
    endcase
  end

  always_comb begin
    unique case (uw.src)
      SRC_SPACE: src_char = CH_SPACE;
      SRC_SIGN:  src_char = sign_char_q;
      SRC_ZERO:  src_char = CH_ZERO;
      SRC_X:     src_char = lower_q ? (CH_X | LOWER_BIT) : CH_X;
      SRC_DIGIT: src_char = digit_char(dig_q[nd_dec[DIG_IDX_W-1:0]], lower_q);
      default:   src_char = CH_SPACE;
    endcase
  end

  // Microcode execution. Emit steps hold until the output register can take a character; loop
  // steps repeat while their counter is nonzero and move on once it runs out or the step's
  // condition is false.
  always_comb begin
    upc_d       = upc_q;
    mag_d       = mag_q;
    quo_d       = quo_q;
    hex_d       = hex_q;
    dec_d       = dec_q;
    zero_d      = zero_q;
    left_d      = left_q;
    lower_d     = lower_q;
    prefix_d    = prefix_q;
    sign_en_d   = sign_en_q;
    sign_char_d = sign_char_q;
    prec_d      = prec_q;
    pad_d       = pad_q;
    nd_d        = nd_q;
    dig_we      = 1'b0;
    emit        = 1'b0;
    out_last_d  = out_last_q;
    out_char_d  = out_char_q;

    unique case (uw.op)
      U_LOAD: begin
        if (in_fire) begin
          mag_d       = req_neg ? (~value_i + 1'b1) : value_i;
          hex_d       = req_hex;
          dec_d       = (base_select_i == BASE_DEC);
          // Left justification overrides zero padding.
          zero_d      = format_flags_i[FLG_ZERO] & ~format_flags_i[FLG_LEFT];
          left_d      = format_flags_i[FLG_LEFT];
          lower_d     = format_flags_i[FLG_LOWER];
          prefix_d    = format_flags_i[FLG_PREFIX];
          sign_en_d   = req_sign_en;
          sign_char_d = req_neg                    ? CH_MINUS :
                        format_flags_i[FLG_PLUS]   ? CH_PLUS  : CH_SPACE;
          prec_d      = req_prec;
          pad_d       = PAD_W'(req_width) - PAD_W'(req_sign_en) - PAD_W'(req_pfx_len);
          nd_d        = '0;
          upc_d       = uw.nxt;
        end
      end
      U_DIV: begin
        quo_d = dec_q ? VALUE_BITS'(prod[PROD_W-1:DEC_SHIFT]) :
                hex_q ? (mag_q >> 4) : (mag_q >> 3);
        upc_d = uw.nxt;
      end
      U_DIG: begin
        // The loop runs at least once, so zero still yields one digit.
        dig_we = 1'b1;
        nd_d   = nd_q + 1'b1;
        mag_d  = quo_q;
        upc_d  = (quo_q != '0) ? uw.alt : uw.nxt;
      end
      U_PREC: begin
        if (FIELD_W'(nd_q) > prec_q) begin
          prec_d = FIELD_W'(nd_q);
        end
        upc_d = uw.nxt;
      end
      U_PAD: begin
        // From here on the pad count is never negative, and the precision count holds only
        // the extra zeros in front of the digits.
        pad_d  = pad_sub[PAD_W-1] ? '0 : pad_sub;
        prec_d = prec_q - FIELD_W'(nd_q);
        upc_d  = uw.nxt;
      end
      U_EMIT_LOOP: begin
        if (!cond_ok || (cnt_val == '0)) begin
          upc_d = uw.nxt;
        end else if (out_free) begin
          emit       = 1'b1;
          out_char_d = src_char;
          // The final character is either the last digit with no trailing spaces left, or
          // the last trailing space.
          out_last_d = (uw.last_dig && (nd_q == ND_W'(1)) && (pad_q == '0))
                     || (uw.last_pad && (pad_q == PAD_W'(1)));
          unique case (uw.cnt)
            CNT_PAD:  pad_d  = pad_q - 1'b1;
            CNT_PREC: prec_d = prec_q - 1'b1;
            CNT_ND:   nd_d   = nd_dec;
            default:  nd_d   = nd_q;
          endcase
        end
      end
      U_EMIT_ONCE: begin
        if (!cond_ok) begin
          upc_d = uw.nxt;
        end else if (out_free) begin
          emit       = 1'b1;
          out_char_d = src_char;
          out_last_d = 1'b0;
          upc_d      = uw.nxt;
        end
      end
      default: begin
        upc_d = uw.nxt;
      end
    endcase

    out_valid_d = emit ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= ST_LOAD;
      out_valid_q <= 1'b0;
    end else begin
      upc_q       <= upc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q       <= mag_d;
    quo_q       <= quo_d;
    hex_q       <= hex_d;
    dec_q       <= dec_d;
    zero_q      <= zero_d;
    left_q      <= left_d;
    lower_q     <= lower_d;
    prefix_q    <= prefix_d;
    sign_en_q   <= sign_en_d;
    sign_char_q <= sign_char_d;
    prec_q      <= prec_d;
    pad_q       <= pad_d;
    nd_q        <= nd_d;
    out_char_q  <= out_char_d;
    out_last_q  <= out_last_d;
  end

  // Digits are collected least significant first and read back from the top.
  always_ff @(posedge clk_i) begin
    if (dig_we) begin
      dig_q[nd_q[DIG_IDX_W-1:0]] <= rem;
    end
  end

endmodule
